/* design/blds_pkg.sv */
// Shared types and codes for the bounded list deque with search.
// Used by blds_cell, blds_ctrl and the top level; depends on nothing.
package blds_pkg;

   localparam int DATA_W = 32;

   // Operation codes carried on the request side
   localparam logic [1:0] MODE_PUSH_FRONT = 2'd0;
   localparam logic [1:0] MODE_PUSH_BACK  = 2'd1;
   localparam logic [1:0] MODE_POP_FRONT  = 2'd2;
   localparam logic [1:0] MODE_SEARCH     = 2'd3;

   // Status codes carried on the response side
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   // Operation that every cell of the chain carries out
   typedef enum logic [1:0] {
      CHAIN_HOLD       = 2'd0,
      CHAIN_SHIFT_UP   = 2'd1,   // take the neighbour nearer the head
      CHAIN_SHIFT_DOWN = 2'd2,   // take the neighbour further from the head
      CHAIN_LOAD       = 2'd3    // the selected cell takes the key
   } chain_op_type;

   typedef struct packed {
      chain_op_type        op;
      logic                wrap;  // tail cell takes the head cell instead of itself
      logic [DATA_W-1:0]   key;
   } chain_cmd_type;

endpackage

/* design/bounded_list_deque_with_search.sv */
// Bounded list deque with search: a chain of DEPTH cells, cell 0 holding the head.
// Push/pop items answer in the next cycle; a new item is taken every cycle while rsp_tready holds.
// A search rotates the whole chain once past the head cell; no item is taken during the walk.
// The next item can be taken with the search result.
// Synchronous active-high reset empties the list; cell contents stay undefined until written.
// Depends on blds_pkg, blds_cell and blds_ctrl.
module bounded_list_deque_with_search #(
   parameter int DEPTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [31:0] value
   input  logic [1:0]   req_tuser,   // [1:0] mode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,   // [5:0] position, [12:6] length, [15:13] zero
   output logic [1:0]   rsp_tuser    // [1:0] status
);
   import blds_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   chain_cmd_type     cmd;
   logic [CW-1:0]     count;
   logic [DATA_W-1:0] cell_data [DEPTH];
   logic [1:0]        rsp_status;
   logic [5:0]        rsp_position;
   logic [6:0]        rsp_length;

   blds_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_value    (req_tdata),
      .req_mode     (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_status   (rsp_status),
      .rsp_position (rsp_position),
      .rsp_length   (rsp_length),
      .head_data    (cell_data[0]),
      .cmd          (cmd),
      .count        (count)
   );

   // build the chain; the head cell takes the key, the tail takes the head when rotating
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left;
      logic [DATA_W-1:0] right;

      if (i == 0) begin : g_head
         assign left = cmd.key;
      end else begin : g_body
         assign left = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right = cmd.wrap ? cell_data[0] : cell_data[i];
      end else begin : g_inner
         assign right = cell_data[i+1];
      end

      blds_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .from_left  (left),
         .from_right (right),
         .load_here  (count == CW'(i)),
         .data_out   (cell_data[i])
      );
   end

   assign rsp_tdata = {3'b000, rsp_length, rsp_position};
   assign rsp_tuser = rsp_status;

   // entry count never exceeds the chain length
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count <= CW'(DEPTH))
      else $error("entry count beyond depth");

   // a push at the head on a non-full list grows it by one
   a_push_grows : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == MODE_PUSH_FRONT && count < CW'(DEPTH))
      |=> count == $past(count) + CW'(1))
      else $error("push front did not grow the list");

   // no item is taken while a search walk is under way
   a_search_busy : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == MODE_SEARCH) |=> !req_tready)
      else $error("item taken during search walk");

   // a pop on an empty list is reported at once
   a_pop_empty : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == MODE_POP_FRONT && count == '0)
      |=> (rsp_tvalid && rsp_tuser == STATUS_EMPTY && count == '0))
      else $error("pop on empty list not reported");

endmodule

/* design/blds_cell.sv */
// One storage cell of the list chain: holds a single entry.
// Depends on blds_pkg for the chain command type.
module blds_cell (
   input  logic                         clock,
   input  blds_pkg::chain_cmd_type      cmd,
   input  logic [blds_pkg::DATA_W-1:0]  from_left,
   input  logic [blds_pkg::DATA_W-1:0]  from_right,
   input  logic                         load_here,
   output logic [blds_pkg::DATA_W-1:0]  data_out
);
   import blds_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   // select the next entry from the neighbours, the key or self
   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         CHAIN_HOLD:       data_in = data_ff;
         CHAIN_SHIFT_UP:   data_in = from_left;
         CHAIN_SHIFT_DOWN: data_in = from_right;
         CHAIN_LOAD: begin
            if (load_here) begin
               data_in = cmd.key;
            end
         end
         default:          data_in = data_ff;
      endcase
   end

   // hold the entry; contents are undefined until written
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

/* design/blds_ctrl.sv */
// Sequencer of the list: handshakes, entry count, search walk and result register.
// Depends on blds_pkg; drives the command shared by all cells of the chain.
module blds_ctrl #(
   parameter int DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [blds_pkg::DATA_W-1:0]       req_value,
   input  logic [1:0]                        req_mode,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [1:0]                        rsp_status,
   output logic [5:0]                        rsp_position,
   output logic [6:0]                        rsp_length,
   input  logic [blds_pkg::DATA_W-1:0]       head_data,
   output blds_pkg::chain_cmd_type           cmd,
   output logic [$clog2(DEPTH+1)-1:0]        count
);
   import blds_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW-1:0] LAST_STEP = IW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   typedef enum logic [1:0] {
      STATE_IDLE   = 2'b01,
      STATE_SEARCH = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [IW-1:0]     step_ff, step_in;
   logic              found_ff, found_in;
   logic [IW-1:0]     hit_ff, hit_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [5:0]        rsp_pos_ff, rsp_pos_in;
   logic [6:0]        rsp_len_ff, rsp_len_in;

   logic              accept;
   logic              live_step;
   logic              match_now;
   logic [IW+5:0]     pos_ext;
   logic [CW+6:0]     len_ext;

   assign req_tready = (state_ff == STATE_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   // compare the entry now at the head cell during the walk
   assign live_step = CW'(step_ff) < count_ff;
   assign match_now = (state_ff == STATE_SEARCH) && !found_ff && live_step
                      && (head_data == key_ff);

   // decide the chain command, the count and the result
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      found_in      = found_ff;
      hit_in        = hit_ff;
      key_in        = key_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_len_in    = rsp_len_ff;
      cmd.op        = CHAIN_HOLD;
      cmd.wrap      = 1'b0;
      cmd.key       = req_value;
      pos_ext       = '0;
      len_ext       = '0;

      case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               rsp_status_in = STATUS_OK;
               rsp_pos_in    = '0;
               case (req_mode)
                  MODE_PUSH_FRONT: begin
                     if (count_ff == FULL_COUNT) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        cmd.op   = CHAIN_SHIFT_UP;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  MODE_PUSH_BACK: begin
                     if (count_ff == FULL_COUNT) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        cmd.op   = CHAIN_LOAD;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  MODE_POP_FRONT: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        cmd.op   = CHAIN_SHIFT_DOWN;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  default: begin
                     // start the walk; the result follows at its end
                     state_in = STATE_SEARCH;
                     step_in  = '0;
                     found_in = 1'b0;
                     hit_in   = '0;
                     key_in   = req_value;
                  end
               endcase
               if (req_mode != MODE_SEARCH) begin
                  len_ext      = {7'b0, count_in};
                  rsp_valid_in = 1'b1;
                  rsp_len_in   = len_ext[6:0];
               end
            end
         end
         STATE_SEARCH: begin
            // rotate the whole chain towards the head so every entry passes it in order
            cmd.op   = CHAIN_SHIFT_DOWN;
            cmd.wrap = 1'b1;
            step_in  = step_ff + IW'(1);
            if (match_now) begin
               found_in = 1'b1;
               hit_in   = step_ff;
            end
            if (step_ff == LAST_STEP) begin
               state_in      = STATE_IDLE;
               pos_ext       = {6'b0, hit_in};
               len_ext       = {7'b0, count_ff};
               rsp_valid_in  = 1'b1;
               rsp_status_in = found_in ? STATUS_OK : STATUS_NOT_FOUND;
               rsp_pos_in    = found_in ? pos_ext[5:0] : 6'd0;
               rsp_len_in    = len_ext[6:0];
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   // advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold walk progress and the result item
   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      found_ff      <= found_in;
      hit_ff        <= hit_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_length   = rsp_len_ff;
   assign count        = count_ff;

endmodule

/* tb/tb.sv */
// Self-checking testbench for bounded_list_deque_with_search: random and directed list operations.
// Predicts status, position and length per item and checks each result in order.
// Depends on blds_pkg and the top level of the block.
`timescale 1ns / 1ps

module tb;
   import blds_pkg::*;

   localparam int LIST_DEPTH  = 64;
   localparam int RAND_ITEMS  = 1350;
   localparam int CALM_ITEMS  = 150;    // final stretch without idling
   localparam int LONG_HOLD   = 300;    // cycles of the long receiver hold-off
   localparam int HOLD_AT     = 500;    // results seen before the long hold-off
   localparam int TAIL_CYCLES = 2 * LIST_DEPTH;

   typedef struct {
      logic [1:0]  mode;
      logic [31:0] value;
      bit          sync;    // wait for every result before offering this item
   } list_req_t;

   typedef struct {
      logic [1:0] status;
      logic [5:0] position;
      logic [6:0] length;
   } list_rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // [31:0] value
   logic [1:0]  req_tuser = '0;    // [1:0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [5:0] position, [12:6] length, [15:13] zero
   logic [1:0]  rsp_tuser;         // [1:0] status

   list_req_t   req_backlog[$];
   list_rsp_t   pending_results[$];
   int          outstanding = 0;
   int          fail_count = 0;
   int          n_total = 0;

   // list contents as the block should hold them
   logic [31:0] list_mem [LIST_DEPTH];
   logic [5:0]  list_head = '0;
   logic [6:0]  list_len = '0;

   // shadow of the list used only to steer the stimulus
   logic [31:0] gen_list[$];

   bounded_list_deque_with_search #(.DEPTH(LIST_DEPTH)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Apply one operation to the list and return the result it should give
   function automatic list_rsp_t deque_apply(input logic [1:0] op, input logic [31:0] val);
      list_rsp_t  r;
      logic       found;
      logic [5:0] slot;
      r.status   = STATUS_OK;
      r.position = '0;
      found      = 1'b0;
      case (op)
         MODE_PUSH_FRONT: begin
            if (list_len == LIST_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               list_head = list_head - 6'd1;
               list_mem[list_head] = val;
               list_len = list_len + 7'd1;
            end
         end
         MODE_PUSH_BACK: begin
            if (list_len == LIST_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               slot = list_head + list_len[5:0];
               list_mem[slot] = val;
               list_len = list_len + 7'd1;
            end
         end
         MODE_POP_FRONT: begin
            if (list_len == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               list_head = list_head + 6'd1;
               list_len = list_len - 7'd1;
            end
         end
         default: begin
            r.status = STATUS_NOT_FOUND;
            for (int i = 0; i < LIST_DEPTH; i++) begin
               slot = list_head + 6'(i);
               if (!found && i < list_len && list_mem[slot] == val) begin
                  found      = 1'b1;
                  r.status   = STATUS_OK;
                  r.position = 6'(i);
               end
            end
         end
      endcase
      r.length = list_len;
      return r;
   endfunction

   // Queue one item and keep the steering shadow in step
   task automatic add_item(input logic [1:0] op, input logic [31:0] val, input bit sync);
      list_req_t it;
      it.mode  = op;
      it.value = val;
      it.sync  = sync;
      req_backlog.push_back(it);
      case (op)
         MODE_PUSH_FRONT: if (gen_list.size() < LIST_DEPTH) gen_list.push_front(val);
         MODE_PUSH_BACK:  if (gen_list.size() < LIST_DEPTH) gen_list.push_back(val);
         MODE_POP_FRONT:  if (gen_list.size() > 0) void'(gen_list.pop_front());
         default: ;
      endcase
   endtask

   // Mix of wide random values, extremes and a small range that gives duplicates
   function automatic logic [31:0] pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) return $urandom;
      if (sel < 6) begin
         case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
         endcase
      end
      return 32'($urandom_range(0, 15));
   endfunction

   // Search mostly for a value held, sometimes for anything
   function automatic logic [31:0] pick_search();
      if (gen_list.size() > 0 && $urandom_range(0, 9) < 6)
         return gen_list[$urandom_range(0, gen_list.size() - 1)];
      return pick_value();
   endfunction

   function automatic logic [1:0] pick_push();
      return $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
   endfunction

   // Build the stimulus, release reset and wait for the run to drain
   initial begin
      int  seg;
      int  n;
      bit  sync;
      bit  first_seg;

      // directed: empty list, extremes, first match, not found, drain past empty
      add_item(MODE_SEARCH,     32'h0000_0005, 1'b0);
      add_item(MODE_POP_FRONT,  32'h0000_0000, 1'b0);
      add_item(MODE_PUSH_BACK,  32'h7FFF_FFFF, 1'b0);
      add_item(MODE_PUSH_FRONT, 32'h8000_0000, 1'b0);
      add_item(MODE_PUSH_BACK,  32'h0000_0000, 1'b0);
      add_item(MODE_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0);
      add_item(MODE_PUSH_BACK,  32'h8000_0000, 1'b0);
      add_item(MODE_SEARCH,     32'h8000_0000, 1'b0);
      add_item(MODE_SEARCH,     32'hFFFF_FFFF, 1'b0);
      add_item(MODE_SEARCH,     32'h0000_0000, 1'b0);
      add_item(MODE_SEARCH,     32'h7FFF_FFFF, 1'b0);
      add_item(MODE_SEARCH,     32'h1234_5678, 1'b0);
      add_item(MODE_SEARCH,     32'h7FFF_FFFE, 1'b0);
      add_item(MODE_POP_FRONT,  32'hFFFF_FFFF, 1'b0);
      add_item(MODE_SEARCH,     32'h8000_0000, 1'b0);
      for (int i = 0; i < 5; i++)
         add_item(MODE_POP_FRONT, $urandom, 1'b0);
      add_item(MODE_SEARCH, 32'h8000_0000, 1'b0);

      // random segments: fill to full, drain past empty, or mixed traffic
      first_seg = 1'b1;
      while (req_backlog.size() < RAND_ITEMS + 21) begin
         seg  = $urandom_range(0, 9);
         sync = first_seg || ($urandom_range(0, 7) == 0);
         first_seg = 1'b0;
         if (seg < 2) begin
            while (gen_list.size() < LIST_DEPTH) begin
               if ($urandom_range(0, 3) == 0) add_item(MODE_SEARCH, pick_search(), sync);
               else add_item(pick_push(), pick_value(), sync);
               sync = 1'b0;
            end
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) add_item(pick_push(), pick_value(), 1'b0);
            add_item(MODE_SEARCH, gen_list[LIST_DEPTH - 1], 1'b0);
            add_item(MODE_SEARCH, pick_search(), 1'b0);
         end else if (seg == 2) begin
            while (gen_list.size() > 0) begin
               if ($urandom_range(0, 3) == 0) add_item(MODE_SEARCH, pick_search(), sync);
               else add_item(MODE_POP_FRONT, $urandom, sync);
               sync = 1'b0;
            end
            n = $urandom_range(1, 2);
            for (int i = 0; i < n; i++) add_item(MODE_POP_FRONT, $urandom, 1'b0);
            add_item(MODE_SEARCH, pick_value(), 1'b0);
         end else begin
            n = $urandom_range(20, 40);
            for (int i = 0; i < n; i++) begin
               seg = $urandom_range(0, 19);
               if (seg < 9) add_item(pick_push(), pick_value(), sync);
               else if (seg < 13) add_item(MODE_POP_FRONT, $urandom, sync);
               else add_item(MODE_SEARCH, pick_search(), sync);
               sync = 1'b0;
            end
         end
      end
      n_total = req_backlog.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_tvalid) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_results.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Give up after a generous fixed time
   initial begin
      #8_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Offer items from the backlog, with random gaps and waits for drain points
   always @(posedge clock) begin
      logic      nv;
      int        gap_left;
      list_req_t it;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else if (!(req_tvalid && !req_tready)) begin
         nv = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (req_backlog.size() != 0) begin
            if (req_backlog[0].sync && (outstanding != 0 || req_tvalid)) begin
               nv = 1'b0;
            end else if (req_backlog.size() > CALM_ITEMS && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(0, 6);
            end else begin
               it = req_backlog.pop_front();
               nv = 1'b1;
               req_tdata <= it.value;
               req_tuser <= it.mode;
            end
         end
         req_tvalid <= nv;
      end
   end

   // Drop ready in random bursts, and once for a long stretch
   always @(posedge clock) begin
      int rsp_seen;
      int stall_left;
      int hold_left;
      bit long_done;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_seen   = 0;
         stall_left = 0;
         hold_left  = 0;
         long_done  = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) rsp_seen++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!long_done && rsp_seen >= HOLD_AT) begin
            long_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_seen < n_total - CALM_ITEMS && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 6);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Predict on each accepted item, check each accepted result against the oldest
   always @(posedge clock) begin
      list_rsp_t want;
      int        n_in;
      int        n_out;
      if (reset) begin
         outstanding <= 0;
      end else begin
         n_in  = 0;
         n_out = 0;
         if (req_tvalid && req_tready) begin
            pending_results.push_back(deque_apply(req_tuser, req_tdata));
            n_in = 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            n_out = 1;
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result, status %0d tdata %h",
                        $time, rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tuser !== want.status) begin
                  $display("%0t: status expected %0d got %0d", $time, want.status, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[5:0] !== want.position) begin
                  $display("%0t: position expected %0d got %0d",
                           $time, want.position, rsp_tdata[5:0]);
                  fail_count++;
               end
               if (rsp_tdata[12:6] !== want.length) begin
                  $display("%0t: length expected %0d got %0d",
                           $time, want.length, rsp_tdata[12:6]);
                  fail_count++;
               end
               if (rsp_tdata[15:13] !== 3'b000) begin
                  $display("%0t: padding expected 0 got %b", $time, rsp_tdata[15:13]);
                  fail_count++;
               end
            end
         end
         outstanding <= outstanding + n_in - n_out;
      end
   end

endmodule
